[design/ray_aabb_slab_test_macros.svh]
// Assertion helpers used by the checker file rats_chk.sv.
`ifndef RAY_AABB_SLAB_TEST_MACROS_SVH
`define RAY_AABB_SLAB_TEST_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RATS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define RATS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[design/rats_pkg.sv]
`default_nettype none
package rats_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int THR_BITS   = 17;

  // numerator magnitude: |bound - origin| < 2^COORD_BITS, scaled by 2^FRAC_BITS
  localparam int NUM_W    = COORD_BITS + FRAC_BITS;
  localparam int DIV_LAT  = NUM_W + 1;
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int ROOT_W   = COORD_BITS;
  localparam int DIST_BITS = COORD_BITS - 1;

  localparam int IN_RAW  = 12 * COORD_BITS;
  localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
  localparam int OUT_RAW = 1 + 3 * COORD_BITS + DIST_BITS;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1);

  // quotient magnitude limits for positive and negative results
  localparam logic [NUM_W-1:0] Q_POS_LIM = {{(NUM_W-COORD_BITS+1){1'b0}},
                                           {(COORD_BITS-1){1'b1}}};
  localparam logic [NUM_W-1:0] Q_NEG_LIM = Q_POS_LIM + NUM_W'(1);

endpackage
`default_nettype wire

[design/rats_div.sv]
`default_nettype none
module rats_div import rats_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [COORD_BITS-1:0] den_i,
  input  logic                  neg_i,
  output coord_t                t_o
);

  // one quotient bit per stage, restoring
  logic [NUM_W-1:0]      num_q [NUM_W];
  logic [COORD_BITS-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0]      quo_q [NUM_W];
  logic [COORD_BITS-1:0] den_q [NUM_W];
  logic                  neg_q [NUM_W];
  coord_t                t_q;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0]      num_in;
    logic [COORD_BITS-1:0] rem_in;
    logic [NUM_W-1:0]      quo_in;
    logic [COORD_BITS-1:0] den_in;
    logic                  neg_in;
    logic [COORD_BITS:0]   trial;
    logic                  ge;
    logic [COORD_BITS:0]   diff;
    logic [COORD_BITS-1:0] rem_d;
    logic [NUM_W-1:0]      quo_d;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign rem_in = '0;
      assign quo_in = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};
    assign rem_d = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
    assign quo_d = {quo_in[NUM_W-2:0], ge};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= {num_in[NUM_W-2:0], 1'b0};
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
        neg_q[k] <= neg_in;
      end
    end
  end

  // sign and saturate the truncated quotient
  logic [NUM_W-1:0] quo_last;
  coord_t           t_d;
  assign quo_last = quo_q[NUM_W-1];

  always_comb begin
    if (neg_q[NUM_W-1]) begin
      t_d = (quo_last > Q_NEG_LIM) ? COORD_MIN : coord_t'(~quo_last[COORD_BITS-1:0] + 1'b1);
    end else begin
      t_d = (quo_last > Q_POS_LIM) ? COORD_MAX : coord_t'(quo_last[COORD_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_d;
    end
  end

  assign t_o = t_q;

endmodule
`default_nettype wire

[design/rats_isqrt.sv]
`default_nettype none
module rats_isqrt import rats_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   n_i,
  output logic [ROOT_W-1:0] root_o
);

  // one root bit per stage, highest first
  logic [SQ_W-1:0] n_q [ROOT_W];
  logic [SQ_W-1:0] r_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT_W = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [SQ_W-1:0] n_in;
    logic [SQ_W-1:0] r_in;
    logic [SQ_W-1:0] trial;
    logic            take;

    if (k == 0) begin : g_first
      assign n_in = n_i;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign trial = r_in + BIT_W;
    assign take  = n_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k] <= take ? (n_in - trial) : n_in;
        r_q[k] <= take ? ((r_in >> 1) + BIT_W) : (r_in >> 1);
      end
    end
  end

  assign root_o = r_q[ROOT_W-1][ROOT_W-1:0];

endmodule
`default_nettype wire

[design/ray_aabb_slab_test.sv]
// A transaction passes through input capture, stage 1, the bit-per-stage
// dividers, stages 2 to 7, the bit-per-stage root and the output register.
// Throughput: one ray-box transaction per cycle; a full output skid stage
// stalls the whole pipeline. Reset (rst_ni low, async) clears all valid
// bits and sets parallel_threshold to 1; data registers are not reset.
`default_nettype none
module ray_aabb_slab_test import rats_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: parallel_threshold
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [THR_BITS-1:0] cfg_data_i,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_min_x, box_min_y,
  // box_min_z, box_max_x, box_max_y, box_max_z (lowest bits first)
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IN_W-1:0]     s_axis_tdata,
  // hit, hit_x, hit_y, hit_z, hit_distance (lowest bits first)
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_W-1:0]    m_axis_tdata
);

  localparam int C = COORD_BITS;

  // ---------------------------------------------------------------------
  // Configuration register, always writable
  // ---------------------------------------------------------------------
  logic [THR_BITS-1:0] thr_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------
  // Global advance: the pipeline moves while the skid stage is empty
  // ---------------------------------------------------------------------
  logic en;
  logic skid_valid_q;
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  // Stage 0: capture the transaction
  logic            v0_q;
  logic [IN_W-1:0] raw0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      raw0_q <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: parallel test, slab numerators and divisor magnitudes
  // ---------------------------------------------------------------------
  coord_t           org_w [3];
  coord_t           dir_w [3];
  coord_t           lo_w  [3];
  coord_t           hi_w  [3];
  logic [C-1:0]     dmag_d [3];
  logic [2:0]       par_d;
  logic             pok_d;
  logic [NUM_W-1:0] num_lo_d [3];
  logic [NUM_W-1:0] num_hi_d [3];
  logic             neg_lo_d [3];
  logic             neg_hi_d [3];

  always_comb begin
    logic       dneg;
    logic [C:0] dlo;
    logic [C:0] dhi;
    logic [C:0] mlo;
    logic [C:0] mhi;
    pok_d = 1'b1;
    for (int a = 0; a < 3; a++) begin
      org_w[a] = raw0_q[a*C +: C];
      dir_w[a] = raw0_q[(3+a)*C +: C];
      lo_w[a]  = raw0_q[(6+a)*C +: C];
      hi_w[a]  = raw0_q[(9+a)*C +: C];
      dneg      = dir_w[a][C-1];
      dmag_d[a] = dneg ? (~dir_w[a] + 1'b1) : dir_w[a];
      par_d[a]  = (dmag_d[a] == '0) ||
                  ({{THR_BITS{1'b0}}, dmag_d[a]} < {{C{1'b0}}, thr_q});
      dlo = {lo_w[a][C-1], lo_w[a]} - {org_w[a][C-1], org_w[a]};
      dhi = {hi_w[a][C-1], hi_w[a]} - {org_w[a][C-1], org_w[a]};
      mlo = dlo[C] ? (~dlo + 1'b1) : dlo;
      mhi = dhi[C] ? (~dhi + 1'b1) : dhi;
      num_lo_d[a] = {mlo[C-1:0], {FRAC_BITS{1'b0}}};
      num_hi_d[a] = {mhi[C-1:0], {FRAC_BITS{1'b0}}};
      neg_lo_d[a] = dlo[C] ^ dneg;
      neg_hi_d[a] = dhi[C] ^ dneg;
      // a parallel axis needs the origin inside its slab
      if (par_d[a] && ((org_w[a] < lo_w[a]) || (org_w[a] > hi_w[a]))) begin
        pok_d = 1'b0;
      end
    end
  end

  logic             v1_q;
  logic [C-1:0]     dmag1_q [3];
  logic [NUM_W-1:0] num_lo1_q [3];
  logic [NUM_W-1:0] num_hi1_q [3];
  logic             neg_lo1_q [3];
  logic             neg_hi1_q [3];
  coord_t           org1_q [3];
  coord_t           dir1_q [3];
  logic [2:0]       par1_q;
  logic             pok1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dmag1_q   <= dmag_d;
      num_lo1_q <= num_lo_d;
      num_hi1_q <= num_hi_d;
      neg_lo1_q <= neg_lo_d;
      neg_hi1_q <= neg_hi_d;
      org1_q    <= org_w;
      dir1_q    <= dir_w;
      par1_q    <= par_d;
      pok1_q    <= pok_d;
    end
  end

  // ---------------------------------------------------------------------
  // Slab dividers, six in parallel, with the item's sideband alongside
  // ---------------------------------------------------------------------
  coord_t t_lo [3];
  coord_t t_hi [3];

  for (genvar a = 0; a < 3; a++) begin : g_div
    rats_div u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_lo1_q[a]),
      .den_i (dmag1_q[a]),
      .neg_i (neg_lo1_q[a]),
      .t_o   (t_lo[a])
    );
    rats_div u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_hi1_q[a]),
      .den_i (dmag1_q[a]),
      .neg_i (neg_hi1_q[a]),
      .t_o   (t_hi[a])
    );
  end

  logic       vd_q   [DIV_LAT];
  coord_t     orgd_q [DIV_LAT][3];
  coord_t     dird_q [DIV_LAT][3];
  logic [2:0] pard_q [DIV_LAT];
  logic       pokd_q [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_dside
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vd_q[k] <= 1'b0;
        end else if (en) begin
          vd_q[k] <= v1_q;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          orgd_q[k] <= org1_q;
          dird_q[k] <= dir1_q;
          pard_q[k] <= par1_q;
          pokd_q[k] <= pok1_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vd_q[k] <= 1'b0;
        end else if (en) begin
          vd_q[k] <= vd_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          orgd_q[k] <= orgd_q[k-1];
          dird_q[k] <= dird_q[k-1];
          pard_q[k] <= pard_q[k-1];
          pokd_q[k] <= pokd_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: order each slab's entry and exit
  // ---------------------------------------------------------------------
  logic       v2_q;
  coord_t     t1_q [3];
  coord_t     t2_q [3];
  coord_t     org2_q [3];
  coord_t     dir2_q [3];
  logic [2:0] par2_q;
  logic       pok2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= vd_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        t1_q[a] <= (t_lo[a] > t_hi[a]) ? t_hi[a] : t_lo[a];
        t2_q[a] <= (t_lo[a] > t_hi[a]) ? t_lo[a] : t_hi[a];
      end
      org2_q <= orgd_q[DIV_LAT-1];
      dir2_q <= dird_q[DIV_LAT-1];
      par2_q <= pard_q[DIV_LAT-1];
      pok2_q <= pokd_q[DIV_LAT-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: narrow [0, max] over the non-parallel axes
  // ---------------------------------------------------------------------
  coord_t tmin_d;
  coord_t tmax_d;
  logic   hit3_d;

  always_comb begin
    tmin_d = '0;
    tmax_d = COORD_MAX;
    for (int a = 0; a < 3; a++) begin
      if (!par2_q[a]) begin
        if (t1_q[a] > tmin_d) begin
          tmin_d = t1_q[a];
        end
        if (t2_q[a] < tmax_d) begin
          tmax_d = t2_q[a];
        end
      end
    end
    hit3_d = pok2_q && !(tmin_d > tmax_d);
  end

  logic   v3_q;
  logic   hit3_q;
  coord_t tmin3_q;
  coord_t org3_q [3];
  coord_t dir3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit3_q  <= hit3_d;
      tmin3_q <= tmin_d;
      org3_q  <= org2_q;
      dir3_q  <= dir2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: tMin times direction
  // ---------------------------------------------------------------------
  logic                  v4_q;
  logic                  hit4_q;
  logic signed [2*C-1:0] prod4_q [3];
  coord_t                org4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        prod4_q[a] <= tmin3_q * dir3_q[a];
      end
      hit4_q <= hit3_q;
      org4_q <= org3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: floor shift, add origin, saturate the entry point
  // ---------------------------------------------------------------------
  coord_t pt5_d [3];

  always_comb begin
    logic signed [2*C-1:0] sh;
    logic [2*C:0]          sum;
    for (int a = 0; a < 3; a++) begin
      sh  = prod4_q[a] >>> FRAC_BITS;
      sum = {sh[2*C-1], sh} + {{(C+1){org4_q[a][C-1]}}, org4_q[a]};
      if ((sum[2*C:C-1] == '0) || (sum[2*C:C-1] == '1)) begin
        pt5_d[a] = sum[C-1:0];
      end else begin
        pt5_d[a] = sum[2*C] ? COORD_MIN : COORD_MAX;
      end
    end
  end

  logic   v5_q;
  logic   hit5_q;
  coord_t pt5_q  [3];
  coord_t org5_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit5_q <= hit4_q;
      pt5_q  <= pt5_d;
      org5_q <= org4_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: per-axis offset and its square
  // ---------------------------------------------------------------------
  logic [2*C-3:0] sq6_d [3];
  logic           big6_d;

  always_comb begin
    logic [C:0] d;
    logic [C:0] m;
    big6_d = 1'b0;
    for (int a = 0; a < 3; a++) begin
      d = {pt5_q[a][C-1], pt5_q[a]} - {org5_q[a][C-1], org5_q[a]};
      m = d[C] ? (~d + 1'b1) : d;
      if (m[C] || m[C-1]) begin
        big6_d = 1'b1;
      end
      sq6_d[a] = m[C-2:0] * m[C-2:0];
    end
  end

  logic           v6_q;
  logic           hit6_q;
  logic           big6_q;
  logic [2*C-3:0] sq6_q [3];
  coord_t         pt6_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit6_q <= hit5_q;
      big6_q <= big6_d;
      sq6_q  <= sq6_d;
      pt6_q  <= pt5_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: sum of squares
  // ---------------------------------------------------------------------
  logic            v7_q;
  logic            hit7_q;
  logic            big7_q;
  logic [SQ_W-1:0] sum7_q;
  coord_t          pt7_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum7_q <= SQ_W'(sq6_q[0]) + SQ_W'(sq6_q[1]) + SQ_W'(sq6_q[2]);
      hit7_q <= hit6_q;
      big7_q <= big6_q;
      pt7_q  <= pt6_q;
    end
  end

  // ---------------------------------------------------------------------
  // Integer square root with the sideband alongside
  // ---------------------------------------------------------------------
  logic [ROOT_W-1:0] root;

  rats_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (sum7_q),
    .root_o (root)
  );

  logic   vs_q   [ROOT_W];
  logic   hits_q [ROOT_W];
  logic   bigs_q [ROOT_W];
  coord_t pts_q  [ROOT_W][3];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sside
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vs_q[k] <= 1'b0;
        end else if (en) begin
          vs_q[k] <= v7_q;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          hits_q[k] <= hit7_q;
          bigs_q[k] <= big7_q;
          pts_q[k]  <= pt7_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vs_q[k] <= 1'b0;
        end else if (en) begin
          vs_q[k] <= vs_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          hits_q[k] <= hits_q[k-1];
          bigs_q[k] <= bigs_q[k-1];
          pts_q[k]  <= pts_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result assembly: clamp the distance, zero everything on a miss
  // ---------------------------------------------------------------------
  logic                 fin_valid;
  logic                 fin_hit;
  logic [DIST_BITS-1:0] dist_w;
  logic [OUT_W-1:0]     fin_data;

  assign fin_valid = vs_q[ROOT_W-1];
  assign fin_hit   = hits_q[ROOT_W-1];
  assign dist_w    = (bigs_q[ROOT_W-1] || root[ROOT_W-1]) ? DIST_MAX
                                                          : root[DIST_BITS-1:0];
  assign fin_data  = fin_hit ? OUT_W'({dist_w, pts_q[ROOT_W-1][2],
                                       pts_q[ROOT_W-1][1], pts_q[ROOT_W-1][0], 1'b1})
                             : '0;

  // ---------------------------------------------------------------------
  // Output register plus skid stage
  // ---------------------------------------------------------------------
  logic             out_valid_q;
  logic [OUT_W-1:0] out_q;
  logic [OUT_W-1:0] skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // drain the skid stage first; the pipeline holds meanwhile
      if (m_axis_tready) begin
        skid_valid_q <= 1'b0;
      end
    end else if (fin_valid) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (fin_valid) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_q <= fin_data;
      end else begin
        out_q <= fin_data;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

[design/rats_chk.sv]
`default_nettype none
`include "ray_aabb_slab_test_macros.svh"
module rats_chk import rats_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [THR_BITS-1:0] cfg_data_i,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [IN_W-1:0]     s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OUT_W-1:0]    m_axis_tdata
);

  // a stalled result holds
  `RATS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // a miss carries no point and no distance
  `RATS_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[OUT_W-1:1] == '0)

  // the input side only stalls behind a waiting result
  `RATS_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid)

  // the register port never back-pressures
  `RATS_ASSERT_NOW(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

endmodule

bind ray_aabb_slab_test rats_chk u_rats_chk (.*);
`default_nettype wire
